[src/mtpm_pkg.sv]
package mtpm_pkg;

  localparam int CLK_W   = 28;   // bus clock register width
  localparam int MVOL_W  = 7;    // master volume register width
  localparam int REQ_W   = 2;
  localparam int CHAN_W  = 3;
  localparam int FREQ_W  = 16;
  localparam int LEVEL_W = 8;
  localparam int PSC_W   = 16;
  localparam int CMP_W   = 10;
  localparam int CFG_IDX_W = 1;

  // Serial divider width: covers the bus clock and the duty numerator.
  localparam int DIV_W = CLK_W;

  localparam int FREQ_LIMIT = 20000;
  localparam int PWM_PERIOD = 1000;
  localparam int PSC_MAX    = 65535;

  localparam logic [CFG_IDX_W-1:0] REG_BUS_CLOCK  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MASTER_VOL = 1'd1;

  localparam logic [CLK_W-1:0]  BUS_CLOCK_RESET  = 28'd42000000;
  localparam logic [MVOL_W-1:0] MASTER_VOL_RESET = 7'd100;

  typedef enum logic [REQ_W-1:0] {
    REQ_PLAY     = 2'd0,
    REQ_STOP     = 2'd1,
    REQ_STOP_ALL = 2'd2,
    REQ_SET_VOL  = 2'd3
  } req_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EVAL,
    ST_MUL,
    ST_PSC_GO,
    ST_PSC_WAIT,
    ST_DUTY_GO,
    ST_DUTY_WAIT,
    ST_FINISH
  } state_t;

endpackage

[src/mtpm_sdiv.sv]
// Restoring divider, one quotient bit per cycle.
module mtpm_sdiv (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [mtpm_pkg::DIV_W-1:0]    dividend,
  input  logic [mtpm_pkg::DIV_W-1:0]    divisor,
  output logic                          done,
  output logic [mtpm_pkg::DIV_W-1:0]    quotient
);

  localparam int W   = mtpm_pkg::DIV_W;
  localparam int CNT_W = $clog2(W + 1);

  logic [W-1:0]     rem;
  logic [W-1:0]     quo;
  logic [W-1:0]     den;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [W:0]       trial;

  assign trial    = {rem, quo[W-1]} - {1'b0, den};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      den <= divisor;
      rem <= '0;
    end else if (busy) begin
      // shift in the next dividend bit, subtract when it fits
      if (!trial[W]) begin
        rem <= trial[W-1:0];
        quo <= {quo[W-2:0], 1'b1};
      end else begin
        rem <= {rem[W-2:0], quo[W-1]};
        quo <= {quo[W-2:0], 1'b0};
      end
    end
  end

endmodule

[src/multichannel_tone_pwm_mixer_unit.sv]
// Tone mixer for a PWM timer with a fixed period of 1000 counts. Each request
// plays a note on one channel, stops one channel, stops all channels or sets
// one channel's volume; every request returns exactly one result. After the
// table update the block scans the channels one per cycle for the active
// channel with the highest frequency (lowest index on a tie), then derives
// the timer prescaler (bus_clock_hz / (f * 1000) - 1, clamped to 1..65535)
// and the duty compare value (vol * master_volume * 1000 / VOLUME_MAX^2) with
// one bit-serial 28-bit divider, used once for each. A sounding tone goes
// through the scan, the multiply and both divider passes before its result,
// a silent outcome ends after the scan, and a request with an out-of-range
// channel skips the scan. One request is worked on at a time; the next is
// taken while the previous result still waits in the output register.
// Configuration writes are registered; the user must make them between
// requests for use from the next request on, which the block does not enforce.
module multichannel_tone_pwm_mixer_unit #(
  parameter int NUM_CHANNELS = 4,
  parameter int VOLUME_MAX   = 100
) (
  input  logic                               clk,
  input  logic                               rst,
  // request channel
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // chan[2:0], tone_freq[18:3], level[26:19], zero fill above
  input  logic [31:0]                        s_axis_tdata,
  // req_type[1:0]
  input  logic [mtpm_pkg::REQ_W-1:0]         s_axis_tuser,
  // result channel
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // tone_on[0], prescaler[16:1], compare[26:17], zero fill above
  output logic [31:0]                        m_axis_tdata,
  // ignored[0]
  output logic                               m_axis_tuser,
  // configuration write port
  input  logic                               cfg_we,
  input  logic [mtpm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mtpm_pkg::CLK_W-1:0]         cfg_data
);

  localparam int VOL_W    = $clog2(VOLUME_MAX + 1);
  localparam int CH_IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int VM_SQ    = VOLUME_MAX * VOLUME_MAX;
  localparam int W        = mtpm_pkg::DIV_W;

  // configuration registers
  logic [mtpm_pkg::CLK_W-1:0]  bus_clock_hz;
  logic [mtpm_pkg::MVOL_W-1:0] master_volume;

  // channel table
  logic [mtpm_pkg::FREQ_W-1:0] chan_freq   [NUM_CHANNELS];
  logic [VOL_W-1:0]            chan_level  [NUM_CHANNELS];
  logic                        chan_active [NUM_CHANNELS];

  // held timer settings
  logic [mtpm_pkg::PSC_W-1:0]  held_prescaler;
  logic                        held_on;
  logic [mtpm_pkg::CMP_W-1:0]  held_compare;

  // work registers
  mtpm_pkg::state_t            state, state_next;
  logic [CH_IDX_W-1:0]         scan_idx;
  logic [mtpm_pkg::FREQ_W-1:0] best_f;
  logic [VOL_W-1:0]            best_v;
  logic [W-1:0]                psc_den;
  logic [2*VOL_W-1:0]          vol_prod;
  logic [W-1:0]                duty_num;
  logic                        ign_flag;

  // output register
  logic                        out_on;
  logic [mtpm_pkg::PSC_W-1:0]  out_psc;
  logic [mtpm_pkg::CMP_W-1:0]  out_cmp;
  logic                        out_ign;

  // request fields
  mtpm_pkg::req_t               in_req;
  logic [mtpm_pkg::CHAN_W-1:0]  in_chan;
  logic [mtpm_pkg::FREQ_W-1:0]  in_freq;
  logic [mtpm_pkg::LEVEL_W-1:0] in_level;
  logic                         in_fire;
  logic                         in_range;
  logic [CH_IDX_W-1:0]          wr_idx;
  logic [VOL_W-1:0]             in_level_c;
  logic [VOL_W-1:0]             mvol_c;
  logic                         tone_ok;

  // divider hookup
  logic         div_start;
  logic [W-1:0] div_dividend;
  logic [W-1:0] div_divisor;
  logic         div_done;
  logic [W-1:0] div_quo;
  logic [mtpm_pkg::PSC_W-1:0] psc_from_quo;
  logic [mtpm_pkg::CMP_W-1:0] cmp_from_quo;
  logic         out_load;

  assign in_req   = mtpm_pkg::req_t'(s_axis_tuser);
  assign in_chan  = s_axis_tdata[2:0];
  assign in_freq  = s_axis_tdata[18:3];
  assign in_level = s_axis_tdata[26:19];

  assign s_axis_tready = (state == mtpm_pkg::ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign in_range      = ({1'b0, in_chan} < 4'(NUM_CHANNELS));
  assign wr_idx        = CH_IDX_W'(in_chan);

  // clamp volumes to VOLUME_MAX
  assign in_level_c = ({1'b0, in_level} > 9'(VOLUME_MAX)) ? VOL_W'(VOLUME_MAX)
                                                          : VOL_W'(in_level);
  assign mvol_c = ({1'b0, master_volume} > 8'(VOLUME_MAX)) ? VOL_W'(VOLUME_MAX)
                                                           : VOL_W'(master_volume);

  assign tone_ok = (best_f != '0) &&
                   ({1'b0, best_f} < 17'(mtpm_pkg::FREQ_LIMIT));

  // prescaler = quotient - 1 with wrap, then clamp to 1..PSC_MAX
  always_comb begin
    if (div_quo == '0) begin
      psc_from_quo = mtpm_pkg::PSC_W'(mtpm_pkg::PSC_MAX);
    end else if (div_quo > W'(mtpm_pkg::PSC_MAX + 1)) begin
      psc_from_quo = mtpm_pkg::PSC_W'(mtpm_pkg::PSC_MAX);
    end else if (div_quo <= W'(2)) begin
      psc_from_quo = mtpm_pkg::PSC_W'(1);
    end else begin
      psc_from_quo = mtpm_pkg::PSC_W'(div_quo - W'(1));
    end
  end

  assign cmp_from_quo = (div_quo > W'(mtpm_pkg::PWM_PERIOD))
                        ? mtpm_pkg::CMP_W'(mtpm_pkg::PWM_PERIOD)
                        : div_quo[mtpm_pkg::CMP_W-1:0];

  assign div_start    = (state == mtpm_pkg::ST_PSC_GO) || (state == mtpm_pkg::ST_DUTY_GO);
  assign div_dividend = (state == mtpm_pkg::ST_PSC_GO) ? W'(bus_clock_hz) : duty_num;
  assign div_divisor  = (state == mtpm_pkg::ST_PSC_GO) ? psc_den : W'(VM_SQ);

  mtpm_sdiv u_sdiv (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mtpm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and output load
  always_comb begin
    state_next = state;
    out_load   = 1'b0;
    case (state)
      mtpm_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (in_req != mtpm_pkg::REQ_STOP_ALL && !in_range) begin
            state_next = mtpm_pkg::ST_FINISH;
          end else begin
            state_next = mtpm_pkg::ST_SCAN;
          end
        end
      end
      mtpm_pkg::ST_SCAN: begin
        if (scan_idx == CH_IDX_W'(NUM_CHANNELS - 1)) begin
          state_next = mtpm_pkg::ST_EVAL;
        end
      end
      mtpm_pkg::ST_EVAL: begin
        state_next = tone_ok ? mtpm_pkg::ST_MUL : mtpm_pkg::ST_FINISH;
      end
      mtpm_pkg::ST_MUL:     state_next = mtpm_pkg::ST_PSC_GO;
      mtpm_pkg::ST_PSC_GO:  state_next = mtpm_pkg::ST_PSC_WAIT;
      mtpm_pkg::ST_PSC_WAIT: begin
        if (div_done) begin
          state_next = mtpm_pkg::ST_DUTY_GO;
        end
      end
      mtpm_pkg::ST_DUTY_GO: state_next = mtpm_pkg::ST_DUTY_WAIT;
      mtpm_pkg::ST_DUTY_WAIT: begin
        if (div_done) begin
          state_next = mtpm_pkg::ST_FINISH;
        end
      end
      mtpm_pkg::ST_FINISH: begin
        // hold the result until the output register is free
        if (!m_axis_tvalid || m_axis_tready) begin
          out_load   = 1'b1;
          state_next = mtpm_pkg::ST_IDLE;
        end
      end
      default: state_next = mtpm_pkg::ST_IDLE;
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      bus_clock_hz  <= mtpm_pkg::BUS_CLOCK_RESET;
      master_volume <= mtpm_pkg::MASTER_VOL_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        mtpm_pkg::REG_BUS_CLOCK:  bus_clock_hz  <= cfg_data;
        mtpm_pkg::REG_MASTER_VOL: master_volume <= cfg_data[mtpm_pkg::MVOL_W-1:0];
        default: ;
      endcase
    end
  end

  // channel table update on an accepted request
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_CHANNELS; k++) begin
        chan_freq[k]   <= '0;
        chan_level[k]  <= '0;
        chan_active[k] <= 1'b0;
      end
    end else if (in_fire) begin
      case (in_req)
        mtpm_pkg::REQ_STOP_ALL: begin
          for (int k = 0; k < NUM_CHANNELS; k++) begin
            chan_freq[k]   <= '0;
            chan_level[k]  <= '0;
            chan_active[k] <= 1'b0;
          end
        end
        mtpm_pkg::REQ_PLAY: begin
          if (in_range) begin
            chan_freq[wr_idx]   <= in_freq;
            chan_level[wr_idx]  <= in_level_c;
            chan_active[wr_idx] <= (in_freq != '0);
          end
        end
        mtpm_pkg::REQ_STOP: begin
          if (in_range) begin
            chan_freq[wr_idx]   <= '0;
            chan_level[wr_idx]  <= '0;
            chan_active[wr_idx] <= 1'b0;
          end
        end
        mtpm_pkg::REQ_SET_VOL: begin
          if (in_range) begin
            chan_level[wr_idx] <= in_level_c;
          end
        end
        default: ;
      endcase
    end
  end

  // held timer settings
  always_ff @(posedge clk) begin
    if (rst) begin
      held_prescaler <= '0;
      held_on        <= 1'b0;
      held_compare   <= '0;
    end else begin
      if (state == mtpm_pkg::ST_EVAL && !tone_ok) begin
        // silence: keep the prescaler, drop the compare
        held_on      <= 1'b0;
        held_compare <= '0;
      end
      if (state == mtpm_pkg::ST_PSC_WAIT && div_done) begin
        held_prescaler <= psc_from_quo;
      end
      if (state == mtpm_pkg::ST_DUTY_WAIT && div_done) begin
        held_compare <= cmp_from_quo;
        held_on      <= 1'b1;
      end
    end
  end

  // scan and arithmetic work registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      scan_idx <= '0;
      best_f   <= '0;
      best_v   <= '0;
      ign_flag <= (in_req != mtpm_pkg::REQ_STOP_ALL) && !in_range;
    end else if (state == mtpm_pkg::ST_SCAN) begin
      // strict compare keeps the lowest index on a tie
      if (chan_active[scan_idx] && chan_freq[scan_idx] > best_f) begin
        best_f <= chan_freq[scan_idx];
        best_v <= chan_level[scan_idx];
      end
      scan_idx <= scan_idx + 1'b1;
    end
    if (state == mtpm_pkg::ST_MUL) begin
      psc_den  <= W'(best_f) * W'(mtpm_pkg::PWM_PERIOD);
      vol_prod <= (2*VOL_W)'(best_v) * (2*VOL_W)'(mvol_c);
    end
    if (state == mtpm_pkg::ST_PSC_GO) begin
      duty_num <= W'(vol_prod) * W'(mtpm_pkg::PWM_PERIOD);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_on  <= held_on;
      out_psc <= held_prescaler;
      out_cmp <= held_compare;
      out_ign <= ign_flag;
    end
  end

  assign m_axis_tdata = {5'd0, out_cmp, out_psc, out_on};
  assign m_axis_tuser = out_ign;

endmodule

[tb/tb_multichannel_tone_pwm_mixer_unit.sv]
module tb_multichannel_tone_pwm_mixer_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_CH      = 4;
  localparam int VOL_MAX     = 100;
  localparam int CH_IDX_W    = $clog2(NUM_CH);
  // Drain time, sized to cover the longest request-to-result path.
  localparam int DRAIN_CYCLES = NUM_CH + 72;
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 1200000;
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_ITEMS   = 150;

  // One tone result, as the timer would be programmed.
  typedef struct packed {
    logic        running;
    logic [15:0] psc;
    logic [9:0]  duty;
    logic        ignored;
  } tone_result_t;

  logic                           clk;
  logic                           rst;
  logic                           s_axis_tvalid;
  logic                           s_axis_tready;
  logic [31:0]                    s_axis_tdata;   // chan[2:0], tone_freq[18:3], level[26:19]
  logic [mtpm_pkg::REQ_W-1:0]     s_axis_tuser;   // req_type[1:0]
  logic                           m_axis_tvalid;
  logic                           m_axis_tready;
  logic [31:0]                    m_axis_tdata;   // tone_on[0], prescaler[16:1], compare[26:17]
  logic                           m_axis_tuser;   // ignored[0]
  logic                           cfg_we;
  logic [mtpm_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [mtpm_pkg::CLK_W-1:0]     cfg_data;

  // Mirror of the channel table, the held timer setup and the registers.
  logic [15:0]                 chan_hz [NUM_CH];
  logic [6:0]                  chan_vol [NUM_CH];
  logic                        chan_on [NUM_CH];
  logic [15:0]                 held_psc;
  logic                        held_running;
  logic [9:0]                  held_duty;
  logic [mtpm_pkg::CLK_W-1:0]  bus_hz;
  logic [mtpm_pkg::MVOL_W-1:0] master_vol;

  tone_result_t pending_tones[$];
  int           mismatches;
  bit           gaps_on;
  bit           stalls_on;

  multichannel_tone_pwm_mixer_unit #(
    .NUM_CHANNELS(NUM_CH),
    .VOLUME_MAX  (VOL_MAX)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard stop: no correct run comes anywhere near this many cycles.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("multichannel_tone_pwm_mixer_unit test failed");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("%0t: mismatch: %s", $time, msg);
  endtask

  function automatic logic [6:0] clamp_vol(input logic [7:0] v);
    return (v > VOL_MAX) ? 7'(VOL_MAX) : v[6:0];
  endfunction

  // Pick the highest-pitched active channel and reprogram the held timer setup.
  function automatic void retune_timer();
    logic [15:0] best_hz;
    logic [6:0]  best_vol;
    logic [31:0] divisor;
    logic [31:0] psc;
    logic [31:0] duty;
    best_hz  = '0;
    best_vol = '0;
    for (int k = 0; k < NUM_CH; k++) begin
      // strict compare keeps the lowest index on a tie
      if (chan_on[k] && chan_hz[k] > best_hz) begin
        best_hz  = chan_hz[k];
        best_vol = chan_vol[k];
      end
    end
    if (best_hz != 0 && best_hz < mtpm_pkg::FREQ_LIMIT) begin
      divisor = 32'(best_hz) * 32'(mtpm_pkg::PWM_PERIOD);
      // a zero quotient wraps to all ones and saturates below
      psc = 32'(bus_hz) / divisor - 32'd1;
      if (psc > 32'(mtpm_pkg::PSC_MAX)) psc = 32'(mtpm_pkg::PSC_MAX);
      if (psc < 32'd1) psc = 32'd1;
      duty = 32'(best_vol) * 32'(clamp_vol({1'b0, master_vol}))
             * 32'(mtpm_pkg::PWM_PERIOD) / 32'(VOL_MAX * VOL_MAX);
      if (duty > 32'(mtpm_pkg::PWM_PERIOD)) duty = 32'(mtpm_pkg::PWM_PERIOD);
      held_psc     = psc[15:0];
      held_duty    = duty[9:0];
      held_running = 1'b1;
    end else begin
      // silence keeps the old prescaler
      held_running = 1'b0;
      held_duty    = '0;
    end
  endfunction

  // Apply one accepted request to the mirror and queue the result it must give.
  function automatic void apply_request(input mtpm_pkg::req_t kind, input logic [2:0] ch,
                                        input logic [15:0] hz, input logic [7:0] lvl);
    logic                ign;
    logic [CH_IDX_W-1:0] idx;
    ign = 1'b0;
    idx = CH_IDX_W'(ch);
    if (kind == mtpm_pkg::REQ_STOP_ALL) begin
      for (int k = 0; k < NUM_CH; k++) begin
        chan_on[k]  = 1'b0;
        chan_hz[k]  = '0;
        chan_vol[k] = '0;
      end
      retune_timer();
    end else if (ch >= NUM_CH) begin
      ign = 1'b1;
    end else begin
      case (kind)
        mtpm_pkg::REQ_PLAY: begin
          chan_hz[idx]  = hz;
          chan_vol[idx] = clamp_vol(lvl);
          chan_on[idx]  = (hz != 0);
        end
        mtpm_pkg::REQ_STOP: begin
          chan_on[idx]  = 1'b0;
          chan_hz[idx]  = '0;
          chan_vol[idx] = '0;
        end
        default: begin
          chan_vol[idx] = clamp_vol(lvl);
        end
      endcase
      retune_timer();
    end
    pending_tones.push_back('{held_running, held_psc, held_duty, ign});
  endfunction

  function automatic int pick_gap();
    int r;
    if (!gaps_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 85) return $urandom_range(1, 4);
    return $urandom_range(5, 80);
  endfunction

  // Send one request; valid stays high afterwards so back-to-back requests
  // never drop it in between.
  task automatic send_request(input mtpm_pkg::req_t kind, input logic [2:0] ch,
                              input logic [15:0] hz, input logic [7:0] lvl);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'd0, lvl, hz, ch};
    s_axis_tuser  <= kind;
    @(posedge clk);
    while (s_axis_tready !== 1'b1) @(posedge clk);
    apply_request(kind, ch, hz, lvl);
  endtask

  // Drop valid and hold until every pending result is back and the block is idle.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (pending_tones.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [mtpm_pkg::CFG_IDX_W-1:0] idx,
                           input logic [mtpm_pkg::CLK_W-1:0] value);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == mtpm_pkg::REG_BUS_CLOCK) bus_hz = value;
    else master_vol = value[mtpm_pkg::MVOL_W-1:0];
  endtask

  // Every request kind, clamping, ties, the out-of-band pitch and ignored channels.
  task automatic test_request_kinds();
    send_request(mtpm_pkg::REQ_PLAY, 3'd0, 16'd440, 8'd50);
    send_request(mtpm_pkg::REQ_PLAY, 3'd1, 16'd880, 8'd255);     // level clamps to max
    send_request(mtpm_pkg::REQ_PLAY, 3'd2, 16'd880, 8'd30);      // tie: channel 1 stays
    send_request(mtpm_pkg::REQ_PLAY, 3'd3, 16'd19999, 8'd100);   // top of the audible band
    send_request(mtpm_pkg::REQ_PLAY, 3'd3, 16'd20000, 8'd100);   // out of band: silent
    send_request(mtpm_pkg::REQ_PLAY, 3'd3, 16'hFFFF, 8'd0);
    send_request(mtpm_pkg::REQ_STOP, 3'd3, 16'd0, 8'd0);
    send_request(mtpm_pkg::REQ_SET_VOL, 3'd1, 16'd0, 8'd7);
    send_request(mtpm_pkg::REQ_SET_VOL, 3'd3, 16'd0, 8'd90);     // idle channel stays off
    send_request(mtpm_pkg::REQ_PLAY, 3'd0, 16'd0, 8'd100);       // zero pitch deactivates
    send_request(mtpm_pkg::REQ_PLAY, 3'd4, 16'd1234, 8'd60);     // out-of-range channel
    send_request(mtpm_pkg::REQ_STOP, 3'd7, 16'd0, 8'd0);
    send_request(mtpm_pkg::REQ_SET_VOL, 3'd5, 16'd0, 8'd255);
    send_request(mtpm_pkg::REQ_STOP_ALL, 3'd7, 16'hFFFF, 8'hFF); // channel is don't-care
    send_request(mtpm_pkg::REQ_PLAY, 3'd0, 16'd1, 8'd100);
    send_request(mtpm_pkg::REQ_STOP, 3'd0, 16'd0, 8'd0);
  endtask

  // Bus clock extremes: zero, too slow, prescaler floor and ceiling.
  task automatic test_bus_clock_extremes();
    write_reg(mtpm_pkg::REG_BUS_CLOCK, '0);
    send_request(mtpm_pkg::REQ_PLAY, 3'd0, 16'd1, 8'd100);
    write_reg(mtpm_pkg::REG_BUS_CLOCK, 28'd1000);                // quotient 1: floor at 1
    send_request(mtpm_pkg::REQ_PLAY, 3'd1, 16'd1, 8'd40);
    write_reg(mtpm_pkg::REG_BUS_CLOCK, 28'hFFFFFFF);
    send_request(mtpm_pkg::REQ_PLAY, 3'd2, 16'd19999, 8'd70);
    write_reg(mtpm_pkg::REG_BUS_CLOCK, 28'd200000000);
    send_request(mtpm_pkg::REQ_STOP, 3'd2, 16'd0, 8'd0);         // ceiling, tie to channel 0
    send_request(mtpm_pkg::REQ_PLAY, 3'd3, 16'd19999, 8'd10);
    write_reg(mtpm_pkg::REG_BUS_CLOCK, mtpm_pkg::BUS_CLOCK_RESET);
  endtask

  // Master volume at zero, above the clamp and in between.
  task automatic test_master_volume();
    send_request(mtpm_pkg::REQ_STOP_ALL, 3'd0, 16'd0, 8'd0);
    send_request(mtpm_pkg::REQ_PLAY, 3'd0, 16'd440, 8'd100);
    write_reg(mtpm_pkg::REG_MASTER_VOL, '0);
    send_request(mtpm_pkg::REQ_SET_VOL, 3'd0, 16'd0, 8'd100);
    write_reg(mtpm_pkg::REG_MASTER_VOL, 28'd127);
    send_request(mtpm_pkg::REQ_SET_VOL, 3'd0, 16'd0, 8'd100);
    write_reg(mtpm_pkg::REG_MASTER_VOL, 28'd55);
    send_request(mtpm_pkg::REQ_SET_VOL, 3'd0, 16'd0, 8'd73);
    write_reg(mtpm_pkg::REG_MASTER_VOL, 28'(mtpm_pkg::MASTER_VOL_RESET));
  endtask

  // Random request mix over several register settings and idling patterns.
  task automatic test_random_mix();
    int             r;
    mtpm_pkg::req_t kind;
    logic [2:0]     ch;
    logic [15:0]    hz;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      // first phase runs flat out; the rest mix idling on either side
      gaps_on   = (phase != 0) && (phase % 3 != 1);
      stalls_on = (phase != 0) && (phase % 3 != 2);
      if (phase != 0) begin
        r = $urandom_range(0, 99);
        if (r < 10) begin
          write_reg(mtpm_pkg::REG_BUS_CLOCK, 28'($urandom_range(0, 5000)));
        end else if (r < 20) begin
          write_reg(mtpm_pkg::REG_BUS_CLOCK, 28'($urandom()));
        end else if (r < 30) begin
          write_reg(mtpm_pkg::REG_BUS_CLOCK, (r < 25) ? 28'd1 : 28'd200000000);
        end else begin
          write_reg(mtpm_pkg::REG_BUS_CLOCK, 28'($urandom_range(1000000, 200000000)));
        end
        write_reg(mtpm_pkg::REG_MASTER_VOL, 28'($urandom_range(0, 127)));
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // hold off once per phase until the block has drained
        if (n == PHASE_ITEMS / 2) settle();
        r = $urandom_range(0, 99);
        if (r < 45)      kind = mtpm_pkg::REQ_PLAY;
        else if (r < 60) kind = mtpm_pkg::REQ_STOP;
        else if (r < 65) kind = mtpm_pkg::REQ_STOP_ALL;
        else             kind = mtpm_pkg::REQ_SET_VOL;
        if ($urandom_range(0, 99) < 85) ch = 3'($urandom_range(0, NUM_CH - 1));
        else ch = 3'($urandom_range(NUM_CH, 7));
        r = $urandom_range(0, 99);
        if (r < 5) begin
          hz = '0;
        end else if (r < 15) begin
          // a small pool of pitches makes ties common
          case ($urandom_range(0, 3))
            0: hz = 16'd440;
            1: hz = 16'd880;
            2: hz = 16'd1000;
            default: hz = 16'd19999;
          endcase
        end else if (r < 70) begin
          hz = 16'($urandom_range(1, 19999));
        end else if (r < 80) begin
          hz = 16'($urandom_range(20000, 65535));
        end else begin
          hz = 16'($urandom());
        end
        send_request(kind, ch, hz, 8'($urandom_range(0, 255)));
      end
    end
  endtask

  // Result side: random back-pressure, and check each accepted result
  // against the oldest pending expectation.
  initial begin
    int           stall_left;
    int           r;
    tone_result_t want;
    stall_left = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) begin
        if (pending_tones.size() == 0) begin
          report_mismatch($sformatf("result %h/%b with nothing pending",
                                    m_axis_tdata, m_axis_tuser));
        end else begin
          want = pending_tones.pop_front();
          if (m_axis_tdata[0] !== want.running)
            report_mismatch($sformatf("tone_on got %b want %b", m_axis_tdata[0], want.running));
          if (m_axis_tdata[16:1] !== want.psc)
            report_mismatch($sformatf("prescaler got %0d want %0d",
                                      m_axis_tdata[16:1], want.psc));
          if (m_axis_tdata[26:17] !== want.duty)
            report_mismatch($sformatf("compare got %0d want %0d",
                                      m_axis_tdata[26:17], want.duty));
          if (m_axis_tuser !== want.ignored)
            report_mismatch($sformatf("ignored got %b want %b", m_axis_tuser, want.ignored));
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (stalls_on) begin
          r = $urandom_range(0, 99);
          if (r >= 95)      stall_left = $urandom_range(5, 80);
          else if (r >= 75) stall_left = $urandom_range(1, 4);
        end
      end
    end
  end

  initial begin
    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= mtpm_pkg::REQ_PLAY;
    cfg_we        <= 1'b0;
    cfg_index     <= mtpm_pkg::REG_BUS_CLOCK;
    cfg_data      <= '0;
    mismatches    = 0;
    gaps_on       = 1'b1;
    stalls_on     = 1'b1;
    bus_hz        = mtpm_pkg::BUS_CLOCK_RESET;
    master_vol    = mtpm_pkg::MASTER_VOL_RESET;
    held_psc      = '0;
    held_running  = 1'b0;
    held_duty     = '0;
    for (int k = 0; k < NUM_CH; k++) begin
      chan_hz[k]  = '0;
      chan_vol[k] = '0;
      chan_on[k]  = 1'b0;
    end
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    test_request_kinds();
    test_bus_clock_extremes();
    test_master_volume();
    test_random_mix();

    // drain, then leave room for any stray result
    s_axis_tvalid <= 1'b0;
    while (pending_tones.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("multichannel_tone_pwm_mixer_unit test passed");
    end else begin
      $display("multichannel_tone_pwm_mixer_unit test failed");
    end
    $finish;
  end

endmodule
